// ===== src/multi_token_stream_matcher_top_defines.svh =====
// Assertion macros for the multi-token stream matcher.
// Taken in by the top level; no other dependencies.
`ifndef MULTI_TOKEN_STREAM_MATCHER_TOP_DEFINES_SVH
`define MULTI_TOKEN_STREAM_MATCHER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MTSM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MTSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mtsm_pkg.sv =====
// Shared constants, operation codes and inter-module structs of the matcher.
// No dependencies.
package mtsm_pkg;

  // Default table geometry
  localparam int MAX_TOKENS_DEF    = 8;
  localparam int MAX_TOKEN_LEN_DEF = 16;

  // Field widths of the words
  localparam int OP_W     = 2;
  localparam int IDENT_W  = 16;
  localparam int LEN_IN_W = 5;
  localparam int IDX_IN_W = 4;
  localparam int BYTE_W   = 8;

  // Command fields sized for the largest supported table (64 x 256)
  localparam int SLOT_W = 6;
  localparam int LEN_W  = 9;
  localparam int ADDR_W = 8;
  localparam int CNT_W  = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;
  localparam logic [OP_W-1:0] OP_SCAN   = 2'd3;

  // Classified command handed from front to back
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic               act;    // append/write takes effect
    logic [SLOT_W-1:0]  slot;   // token touched by append/write
    logic [IDENT_W-1:0] ident;
    logic [LEN_W-1:0]   len;    // saturated token length
    logic [ADDR_W-1:0]  addr;   // byte position for write
    logic [BYTE_W-1:0]  ch;
    logic               last;
    logic [CNT_W-1:0]   count;  // tokens loaded when the word came in
  } cmd_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } queue_stat_t;

  typedef struct packed {
    logic popped;
    logic popped_scan;
  } back_stat_t;

endpackage

// ===== src/mtsm_if.sv =====
// Valid/ready channel interfaces for input words and result words.
// Depends on mtsm_pkg.
interface mtsm_item_if;
  logic                           valid;
  logic                           ready;
  logic [mtsm_pkg::OP_W-1:0]      operation;
  logic [mtsm_pkg::IDENT_W-1:0]   token_ident;
  logic [mtsm_pkg::LEN_IN_W-1:0]  token_length;
  logic [mtsm_pkg::IDX_IN_W-1:0]  char_index;
  logic [mtsm_pkg::BYTE_W-1:0]    char_value;
  logic                           last_byte;

  modport source (output valid, operation, token_ident, token_length, char_index,
                  char_value, last_byte, input ready);
  modport sink (input valid, operation, token_ident, token_length, char_index,
                char_value, last_byte, output ready);
endinterface

interface mtsm_result_if;
  logic                         valid;
  logic                         ready;
  logic                         matched;
  logic [mtsm_pkg::IDENT_W-1:0] found_ident;
  logic                         table_empty;

  modport source (output valid, matched, found_ident, table_empty, input ready);
  modport sink (input valid, matched, found_ident, table_empty, output ready);
endinterface

// ===== src/mtsm_ram.sv =====
// Generic single-write, single-read RAM with registered read (read-first).
// Depends on mtsm_pkg for default sizes.
module mtsm_ram #(
  parameter int WIDTH = mtsm_pkg::BYTE_W,
  parameter int DEPTH = mtsm_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/mtsm_front.sv =====
// Front end: accepts input words, tracks the token count and classifies
// each word into a command for the back end. Depends on mtsm_pkg, mtsm_if.
module mtsm_front #(
  parameter int MAX_TOKENS    = mtsm_pkg::MAX_TOKENS_DEF,
  parameter int MAX_TOKEN_LEN = mtsm_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  mtsm_item_if.sink             item,
  input  mtsm_pkg::queue_stat_t q_stat,
  output logic                  push,
  output mtsm_pkg::cmd_t        cmd
);
  localparam int CW = $clog2(MAX_TOKENS + 1);

  logic [CW-1:0]               count;
  logic [CW-1:0]               count_next;
  logic [mtsm_pkg::LEN_W-1:0]  len_in;

  // no words taken while in reset
  assign item.ready = !rst && !q_stat.full;
  assign push       = item.valid && !rst && !q_stat.full;

  // Decode and check table bounds
  always_comb begin
    len_in     = mtsm_pkg::LEN_W'(item.token_length);
    count_next = count;
    cmd        = '0;
    cmd.op     = item.operation;
    cmd.ident  = item.token_ident;
    cmd.addr   = mtsm_pkg::ADDR_W'(item.char_index);
    cmd.ch     = item.char_value;
    cmd.last   = item.last_byte;
    cmd.count  = mtsm_pkg::CNT_W'(count);
    // over-long tokens saturate
    if (len_in > mtsm_pkg::LEN_W'(MAX_TOKEN_LEN)) begin
      cmd.len = mtsm_pkg::LEN_W'(MAX_TOKEN_LEN);
    end else begin
      cmd.len = len_in;
    end
    unique case (item.operation)
      mtsm_pkg::OP_CLEAR: begin
        cmd.act    = 1'b1;
        count_next = '0;
      end
      mtsm_pkg::OP_APPEND: begin
        // full table drops the append
        if (count < CW'(MAX_TOKENS)) begin
          cmd.act    = 1'b1;
          cmd.slot   = mtsm_pkg::SLOT_W'(count);
          count_next = count + CW'(1);
        end
      end
      mtsm_pkg::OP_WRITE: begin
        // goes to the newest token only
        if (count != '0 && int'(item.char_index) < MAX_TOKEN_LEN) begin
          cmd.act  = 1'b1;
          cmd.slot = mtsm_pkg::SLOT_W'(count - CW'(1));
        end
      end
      mtsm_pkg::OP_SCAN: begin
        cmd.act = 1'b1;
      end
      default: begin
        cmd.act = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= count_next;
    end
  end
endmodule

// ===== src/mtsm_queue.sv =====
// Two-entry command queue between front and back end.
// Depends on mtsm_pkg.
module mtsm_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mtsm_pkg::cmd_t        push_cmd,
  input  logic                  pop,
  output mtsm_pkg::cmd_t        head,
  output mtsm_pkg::queue_stat_t stat
);
  localparam logic [1:0] FILL_FULL = 2'd2;

  mtsm_pkg::cmd_t entry [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;

  assign head          = entry[rd_ptr];
  assign stat.full     = (fill == FILL_FULL);
  assign stat.nonempty = (fill != 2'd0);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end
endmodule

// ===== src/mtsm_back.sv =====
// Back end: token table, per-token progress counters and byte RAMs,
// parallel compare, first-match select and the result register.
// Depends on mtsm_pkg, mtsm_if, mtsm_ram.
module mtsm_back #(
  parameter int MAX_TOKENS    = mtsm_pkg::MAX_TOKENS_DEF,
  parameter int MAX_TOKEN_LEN = mtsm_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mtsm_pkg::cmd_t       head,
  input  logic                 head_valid,
  output logic                 pop,
  output mtsm_pkg::back_stat_t stat,
  mtsm_result_if.source        result
);
  localparam int PW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int CW = $clog2(MAX_TOKENS + 1);
  localparam int SW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int AW = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;

  logic [PW-1:0]                progress      [MAX_TOKENS];
  logic [PW-1:0]                progress_next [MAX_TOKENS];
  logic [PW-1:0]                step          [MAX_TOKENS];
  logic [PW-1:0]                tok_len       [MAX_TOKENS];
  logic [mtsm_pkg::IDENT_W-1:0] tok_ident     [MAX_TOKENS];
  logic [mtsm_pkg::BYTE_W-1:0]  rdata         [MAX_TOKENS];
  logic [mtsm_pkg::BYTE_W-1:0]  exp_byte      [MAX_TOKENS];
  logic [mtsm_pkg::BYTE_W-1:0]  fwd_data      [MAX_TOKENS];
  logic [AW-1:0]                raddr         [MAX_TOKENS];
  logic [MAX_TOKENS-1:0]        fwd_valid;
  logic [MAX_TOKENS-1:0]        we;
  logic [MAX_TOKENS-1:0]        hit;
  logic [MAX_TOKENS-1:0]        done;

  logic [SW-1:0]                cmd_slot;
  logic [PW-1:0]                cmd_len;
  logic [AW-1:0]                cmd_addr;
  logic [CW-1:0]                cmd_cnt;
  logic                         is_scan;
  logic                         any_done;
  logic                         emit;
  logic [mtsm_pkg::IDENT_W-1:0] win_ident;

  logic                         out_valid;
  logic                         out_matched;
  logic [mtsm_pkg::IDENT_W-1:0] out_ident;
  logic                         out_empty;

  assign cmd_slot = head.slot[SW-1:0];
  assign cmd_len  = head.len[PW-1:0];
  assign cmd_addr = head.addr[AW-1:0];
  assign cmd_cnt  = head.count[CW-1:0];
  assign is_scan  = (head.op == mtsm_pkg::OP_SCAN);

  // Advance when the result register is free or being drained
  assign pop  = head_valid && (!out_valid || result.ready);
  assign emit = pop && is_scan && (any_done || head.last);

  assign stat.popped      = pop;
  assign stat.popped_scan = pop && is_scan;

  assign result.valid       = out_valid;
  assign result.matched     = out_matched;
  assign result.found_ident = out_ident;
  assign result.table_empty = out_empty;

  // Per-token compare against the prefetched expected byte
  always_comb begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      exp_byte[i] = fwd_valid[i] ? fwd_data[i] : rdata[i];
      if (progress[i] < PW'(MAX_TOKEN_LEN) && head.ch == exp_byte[i]) begin
        step[i] = progress[i] + PW'(1);
      end else begin
        step[i] = '0;
      end
      hit[i]  = (CW'(i) < cmd_cnt);
      done[i] = hit[i] && (step[i] >= tok_len[i]);
    end
  end

  // First completed token in table order wins
  always_comb begin
    any_done  = 1'b0;
    win_ident = '0;
    for (int i = 0; i < MAX_TOKENS; i++) begin
      if (done[i] && !any_done) begin
        any_done  = 1'b1;
        win_ident = tok_ident[i];
      end
    end
  end

  // Next progress per command
  always_comb begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      progress_next[i] = progress[i];
    end
    if (pop) begin
      unique case (head.op)
        mtsm_pkg::OP_CLEAR: begin
          for (int i = 0; i < MAX_TOKENS; i++) begin
            progress_next[i] = '0;
          end
        end
        mtsm_pkg::OP_APPEND: begin
          for (int i = 0; i < MAX_TOKENS; i++) begin
            if (head.act && cmd_slot == SW'(i)) begin
              progress_next[i] = '0;
            end
          end
        end
        mtsm_pkg::OP_WRITE: begin
          for (int i = 0; i < MAX_TOKENS; i++) begin
            progress_next[i] = progress[i];
          end
        end
        mtsm_pkg::OP_SCAN: begin
          for (int i = 0; i < MAX_TOKENS; i++) begin
            if (any_done || head.last) begin
              progress_next[i] = '0;
            end else if (hit[i]) begin
              progress_next[i] = step[i];
            end
          end
        end
        default: begin
          for (int i = 0; i < MAX_TOKENS; i++) begin
            progress_next[i] = progress[i];
          end
        end
      endcase
    end
  end

  // Byte RAM ports: read ahead at next progress, write newest token
  always_comb begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      raddr[i] = progress_next[i][AW-1:0];
      we[i]    = pop && head.op == mtsm_pkg::OP_WRITE && head.act && cmd_slot == SW'(i);
    end
  end

  for (genvar g = 0; g < MAX_TOKENS; g++) begin : g_tok
    mtsm_ram #(
      .WIDTH (mtsm_pkg::BYTE_W),
      .DEPTH (MAX_TOKEN_LEN)
    ) u_bytes (
      .clk   (clk),
      .we    (we[g]),
      .waddr (cmd_addr),
      .wdata (head.ch),
      .raddr (raddr[g]),
      .rdata (rdata[g])
    );
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TOKENS; i++) begin
        progress[i] <= '0;
      end
      fwd_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      for (int i = 0; i < MAX_TOKENS; i++) begin
        progress[i] <= progress_next[i];
        // write hitting the address read this cycle: RAM returns old data
        fwd_valid[i] <= we[i] && (cmd_addr == raddr[i]);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Table and result payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      fwd_data[i] <= head.ch;
      if (pop && head.op == mtsm_pkg::OP_APPEND && head.act && cmd_slot == SW'(i)) begin
        tok_len[i]   <= cmd_len;
        tok_ident[i] <= head.ident;
      end
    end
    if (emit) begin
      out_matched <= any_done;
      out_empty   <= (cmd_cnt == '0);
      if (any_done) begin
        out_ident <= win_ident;
      end else if (cmd_cnt != '0) begin
        out_ident <= tok_ident[0];
      end else begin
        out_ident <= '0;
      end
    end
  end
endmodule

// ===== src/multi_token_stream_matcher_top.sv =====
// Channel   | Dir | Payload
// item      | in  | operation, token_ident, token_length, char_index, char_value, last_byte
// result    | out | matched, found_ident, table_empty
//
// One input word per cycle sustained while no result is held; a scan word is queued at
// the accepting edge, and its result is then registered in the result register.
// Every token compares in parallel against a byte prefetched from its own RAM.
// Reset (rst, synchronous) empties the table, the queue and all counters.
// A held result stalls the back end only; the front keeps taking words until
// the two-entry queue fills.
// Depends on mtsm_pkg, mtsm_if, mtsm_front, mtsm_queue, mtsm_back and the defines header.
`include "multi_token_stream_matcher_top_defines.svh"

module multi_token_stream_matcher_top #(
  parameter int MAX_TOKENS    = mtsm_pkg::MAX_TOKENS_DEF,
  parameter int MAX_TOKEN_LEN = mtsm_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  mtsm_item_if.sink     item,
  mtsm_result_if.source result
);
  mtsm_pkg::queue_stat_t q_stat;
  mtsm_pkg::back_stat_t  b_stat;
  mtsm_pkg::cmd_t        push_cmd;
  mtsm_pkg::cmd_t        head_cmd;
  logic                  push;
  logic                  pop;

  mtsm_front #(
    .MAX_TOKENS    (MAX_TOKENS),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .q_stat (q_stat),
    .push   (push),
    .cmd    (push_cmd)
  );

  mtsm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head_cmd),
    .stat     (q_stat)
  );

  mtsm_back #(
    .MAX_TOKENS    (MAX_TOKENS),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head_cmd),
    .head_valid (q_stat.nonempty),
    .pop        (pop),
    .stat       (b_stat),
    .result     (result)
  );

  // An accepted word is queued or already being worked on the next cycle
  `MTSM_ASSERT_NEXT(a_push_lands, clk, rst, item.valid && item.ready, q_stat.nonempty, "accepted word lost before the queue")

  // A fresh result comes only from a scan word leaving the queue
  `MTSM_ASSERT_NOW(a_result_from_scan, clk, rst, result.valid && !$past(result.valid), $past(b_stat.popped_scan), "result without a scan word")

  // Back end holds while a result waits
  `MTSM_ASSERT_NOW(a_back_stalls, clk, rst, result.valid && !result.ready, !b_stat.popped, "back end advanced over a pending result")
endmodule

// ===== sim/tb_multi_token_stream_matcher_top.sv =====
`timescale 1ns / 100ps
// Testbench for the multi-token stream matcher: random token tables and text, scoreboarded.
// Depends on mtsm_pkg, mtsm_if and multi_token_stream_matcher_top from the RTL.

module tb_multi_token_stream_matcher_top;

  localparam int NTOK        = mtsm_pkg::MAX_TOKENS_DEF;
  localparam int NLEN        = mtsm_pkg::MAX_TOKEN_LEN_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;
  localparam int HOLD_START  = 300;
  localparam int HOLD_LEN    = 250;
  localparam int TARGET_WORDS = 1100;

  typedef struct {
    logic [mtsm_pkg::OP_W-1:0]     op;
    logic [mtsm_pkg::IDENT_W-1:0]  ident;
    logic [mtsm_pkg::LEN_IN_W-1:0] len;
    logic [mtsm_pkg::IDX_IN_W-1:0] idx;
    logic [mtsm_pkg::BYTE_W-1:0]   ch;
    logic                          last;
    bit                            drain;  // hold this word until all results are back
  } matcher_word_t;

  typedef struct packed {
    logic                         matched;
    logic [mtsm_pkg::IDENT_W-1:0] found_ident;
    logic                         table_empty;
  } match_result_t;

  typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

  logic clk;
  logic rst;

  mtsm_item_if   item_bus();
  mtsm_result_if result_bus();

  multi_token_stream_matcher_top dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_bus),
    .result(result_bus)
  );

  always #4 clk = ~clk;

  matcher_word_t pending_words[$];
  match_result_t expected_results[$];
  int            results_outstanding = 0;
  int            error_count = 0;
  int            cycle_count = 0;

  // Predictor state: token table as the block should hold it
  int                           tbl_count;
  logic [mtsm_pkg::IDENT_W-1:0] tbl_ident [NTOK];
  int                           tbl_len [NTOK];
  logic [mtsm_pkg::BYTE_W-1:0]  tbl_bytes [NTOK][NLEN];
  int                           tbl_progress [NTOK];

  // Generator's view of what it loaded, used to build matching text
  int                          gen_count;
  int                          gen_len [NTOK];
  logic [mtsm_pkg::BYTE_W-1:0] gen_bytes [NTOK][NLEN];
  logic [mtsm_pkg::BYTE_W-1:0] alphabet[$];
  bit                          drain_next;

  // Apply one word to the table; returns 1 when it yields a result word
  function automatic bit predict_word(input matcher_word_t w, output match_result_t r);
    int p;
    logic [mtsm_pkg::BYTE_W-1:0] want_byte;
    r = '0;
    case (w.op)
      mtsm_pkg::OP_CLEAR: begin
        tbl_count = 0;
        tbl_progress = '{default: 0};
      end
      mtsm_pkg::OP_APPEND: begin
        if (tbl_count < NTOK) begin
          tbl_ident[tbl_count] = w.ident;
          tbl_len[tbl_count] = (w.len > NLEN) ? NLEN : int'(w.len);
          tbl_progress[tbl_count] = 0;
          tbl_bytes[tbl_count] = '{default: '0};
          tbl_count++;
        end
      end
      mtsm_pkg::OP_WRITE: begin
        if (tbl_count != 0 && w.idx < NLEN) tbl_bytes[tbl_count-1][w.idx] = w.ch;
      end
      default: begin
        // mismatch drops progress to zero without re-testing the byte
        for (int i = 0; i < tbl_count; i++) begin
          p = tbl_progress[i];
          want_byte = (p < NLEN) ? tbl_bytes[i][p] : '0;
          if (w.ch == want_byte && p < NLEN) p++;
          else p = 0;
          tbl_progress[i] = p;
          if (p >= tbl_len[i]) begin
            r.matched = 1'b1;
            r.found_ident = tbl_ident[i];
            r.table_empty = 1'b0;
            tbl_progress = '{default: 0};
            return 1'b1;
          end
        end
        if (w.last) begin
          r.matched = 1'b0;
          r.found_ident = (tbl_count > 0) ? tbl_ident[0] : '0;
          r.table_empty = (tbl_count == 0);
          tbl_progress = '{default: 0};
          return 1'b1;
        end
      end
    endcase
    return 1'b0;
  endfunction

  // Word with every bus field random; callers set the fields the operation uses
  function automatic matcher_word_t make_word(input logic [mtsm_pkg::OP_W-1:0] op);
    matcher_word_t w;
    w.op = op;
    w.ident = mtsm_pkg::IDENT_W'($urandom);
    w.len = mtsm_pkg::LEN_IN_W'($urandom);
    w.idx = mtsm_pkg::IDX_IN_W'($urandom);
    w.ch = mtsm_pkg::BYTE_W'($urandom);
    w.last = 1'($urandom);
    w.drain = 1'b0;
    return w;
  endfunction

  task automatic enqueue_word(input matcher_word_t w);
    w.drain = drain_next;
    drain_next = 1'b0;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic enqueue_fixed(input logic [mtsm_pkg::OP_W-1:0] op,
                               input logic [mtsm_pkg::IDENT_W-1:0] ident,
                               input int len, input int idx,
                               input logic [mtsm_pkg::BYTE_W-1:0] ch, input logic last);
    matcher_word_t w;
    w.op = op;
    w.ident = ident;
    w.len = mtsm_pkg::LEN_IN_W'(len);
    w.idx = mtsm_pkg::IDX_IN_W'(idx);
    w.ch = ch;
    w.last = last;
    w.drain = 1'b0;
    enqueue_word(w);
  endtask

  function automatic logic [mtsm_pkg::BYTE_W-1:0] pick_byte();
    if ($urandom_range(0, 6) == 0) return mtsm_pkg::BYTE_W'($urandom);
    return alphabet[$urandom_range(0, alphabet.size() - 1)];
  endfunction

  // Mostly short tokens; now and then zero, long or over-long
  function automatic int rand_token_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r <= 13) return $urandom_range(1, 4);
    if (r <= 16) return $urandom_range(5, 16);
    return $urandom_range(17, 31);
  endfunction

  // Append a token and write every byte a scan can reach
  task automatic load_token(input logic [mtsm_pkg::IDENT_W-1:0] ident, input int len);
    matcher_word_t w;
    int slot;
    int n;
    w = make_word(mtsm_pkg::OP_APPEND);
    w.ident = ident;
    w.len = mtsm_pkg::LEN_IN_W'(len);
    enqueue_word(w);
    n = (len > NLEN) ? NLEN : len;
    if (gen_count < NTOK) begin
      slot = gen_count;
      gen_len[slot] = n;
      gen_count++;
    end else begin
      slot = NTOK - 1;  // table full: append dropped, writes hit the last token
    end
    if (n == 0) n = 1;
    for (int k = 0; k < n; k++) begin
      w = make_word(mtsm_pkg::OP_WRITE);
      w.idx = mtsm_pkg::IDX_IN_W'(k);
      w.ch = pick_byte();
      gen_bytes[slot][k] = w.ch;
      enqueue_word(w);
    end
  endtask

  // Text built from token copies and filler, with the odd append or rewrite inside
  task automatic send_text(input int n_bytes, input bit finish);
    logic [mtsm_pkg::BYTE_W-1:0] text[$];
    matcher_word_t w;
    int slot;
    int cut;
    while (text.size() < n_bytes) begin
      if (gen_count != 0 && $urandom_range(0, 9) < 6) begin
        slot = $urandom_range(0, gen_count - 1);
        cut = (gen_len[slot] == 0) ? 1 : gen_len[slot];
        if ($urandom_range(0, 3) == 0) cut = $urandom_range(1, cut);
        for (int k = 0; k < cut; k++) text.insert(text.size(), gen_bytes[slot][k]);
      end else begin
        text.insert(text.size(), pick_byte());
      end
    end
    foreach (text[k]) begin
      if ($urandom_range(0, 39) == 0) begin
        load_token(mtsm_pkg::IDENT_W'($urandom), rand_token_len());
      end else if (gen_count != 0 && $urandom_range(0, 29) == 0) begin
        w = make_word(mtsm_pkg::OP_WRITE);
        w.ch = pick_byte();
        gen_bytes[gen_count-1][w.idx] = w.ch;
        enqueue_word(w);
      end
      w = make_word(mtsm_pkg::OP_SCAN);
      w.ch = text[k];
      w.last = finish && (k == text.size() - 1);
      enqueue_word(w);
    end
  endtask

  // Driver: bursts of words with random gaps, waits out drain words
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : driver
    matcher_word_t w;
    if (rst) begin
      item_bus.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!item_bus.valid || item_bus.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        item_bus.valid <= 1'b0;
      end else if (pending_words.size() == 0) begin
        item_bus.valid <= 1'b0;
      end else if (pending_words[0].drain && (item_bus.valid || results_outstanding != 0)) begin
        item_bus.valid <= 1'b0;
      end else begin
        w = pending_words.pop_front();
        item_bus.operation    <= w.op;
        item_bus.token_ident  <= w.ident;
        item_bus.token_length <= w.len;
        item_bus.char_index   <= w.idx;
        item_bus.char_value   <= w.ch;
        item_bus.last_byte    <= w.last;
        item_bus.valid        <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          case ($urandom_range(0, 5))
            0: begin
              burst_left = $urandom_range(40, 80);
              gap_left = 0;
            end
            1: begin
              burst_left = $urandom_range(1, 20);
              gap_left = $urandom_range(10, 25);
            end
            default: begin
              burst_left = $urandom_range(1, 30);
              gap_left = $urandom_range(0, 4);
            end
          endcase
        end
      end
    end
  end

  // Receiver: changing stall pattern plus one long hold-off while words are offered
  rx_mode_t rx_mode = RX_OPEN;
  int rx_mode_left = 0;
  int rx_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin : receiver
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      rx_cycles++;
      if (!hold_done && rx_cycles >= HOLD_START && item_bus.valid) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(20, 150);
      end else begin
        rx_mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   result_bus.ready <= 1'b1;
          RX_RANDOM: result_bus.ready <= 1'($urandom_range(0, 1));
          default:   result_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Monitor: predict on accepted input words, check accepted result words
  always @(posedge clk) begin : monitor
    matcher_word_t w;
    match_result_t r;
    match_result_t want;
    if (rst) begin
      tbl_count = 0;
      tbl_progress = '{default: 0};
      expected_results.delete();
      results_outstanding <= 0;
    end else begin
      if (item_bus.valid && item_bus.ready) begin
        w.op = item_bus.operation;
        w.ident = item_bus.token_ident;
        w.len = item_bus.token_length;
        w.idx = item_bus.char_index;
        w.ch = item_bus.char_value;
        w.last = item_bus.last_byte;
        w.drain = 1'b0;
        if (predict_word(w, r)) expected_results.insert(expected_results.size(), r);
      end
      if (result_bus.valid && result_bus.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: matched %0d found_ident %h table_empty %0d",
                 result_bus.matched, result_bus.found_ident, result_bus.table_empty);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (result_bus.matched !== want.matched) begin
            $error("matched: expected %0d, got %0d", want.matched, result_bus.matched);
            error_count++;
          end
          if (result_bus.found_ident !== want.found_ident) begin
            $error("found_ident: expected %h, got %h", want.found_ident,
                   result_bus.found_ident);
            error_count++;
          end
          if (result_bus.table_empty !== want.table_empty) begin
            $error("table_empty: expected %0d, got %0d", want.table_empty,
                   result_bus.table_empty);
            error_count++;
          end
        end
      end
      results_outstanding <= expected_results.size();
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int session;
    int ntok;
    clk = 1'b0;
    rst = 1'b1;
    item_bus.valid = 1'b0;
    item_bus.operation = mtsm_pkg::OP_CLEAR;
    item_bus.token_ident = '0;
    item_bus.token_length = '0;
    item_bus.char_index = '0;
    item_bus.char_value = '0;
    item_bus.last_byte = 1'b0;
    result_bus.ready = 1'b0;
    drain_next = 1'b0;
    gen_count = 0;

    // Directed: empty-table cases, field extremes, match on the final byte,
    // zero-length token, clear
    enqueue_fixed(mtsm_pkg::OP_WRITE, 16'h0000, 0, 15, 8'hFF, 1'b0);
    enqueue_fixed(mtsm_pkg::OP_SCAN, 16'h0000, 0, 0, 8'h00, 1'b0);
    enqueue_fixed(mtsm_pkg::OP_SCAN, 16'hFFFF, 31, 15, 8'hFF, 1'b1);
    enqueue_fixed(mtsm_pkg::OP_CLEAR, 16'hFFFF, 31, 15, 8'hFF, 1'b1);
    enqueue_fixed(mtsm_pkg::OP_APPEND, 16'hFFFF, 2, 0, 8'h00, 1'b0);
    enqueue_fixed(mtsm_pkg::OP_WRITE, 16'h0000, 0, 0, 8'h00, 1'b0);
    enqueue_fixed(mtsm_pkg::OP_WRITE, 16'h0000, 0, 1, 8'hFF, 1'b0);
    enqueue_fixed(mtsm_pkg::OP_SCAN, 16'h0000, 0, 0, 8'h00, 1'b0);
    enqueue_fixed(mtsm_pkg::OP_SCAN, 16'h0000, 0, 0, 8'hFF, 1'b1);
    enqueue_fixed(mtsm_pkg::OP_SCAN, 16'h0000, 0, 0, 8'h55, 1'b1);
    enqueue_fixed(mtsm_pkg::OP_APPEND, 16'h0000, 0, 0, 8'h00, 1'b0);
    enqueue_fixed(mtsm_pkg::OP_WRITE, 16'h0000, 0, 0, 8'hAA, 1'b0);
    enqueue_fixed(mtsm_pkg::OP_SCAN, 16'h0000, 0, 0, 8'h12, 1'b0);
    enqueue_fixed(mtsm_pkg::OP_SCAN, 16'h0000, 0, 0, 8'h00, 1'b1);
    enqueue_fixed(mtsm_pkg::OP_CLEAR, 16'h0000, 0, 0, 8'h00, 1'b0);

    // Random sessions: load a table, then run strings against it
    session = 0;
    while (pending_words.size() < TARGET_WORDS) begin
      if (session == 2 || session % 5 == 4) drain_next = 1'b1;
      alphabet.delete();
      repeat ($urandom_range(2, 4)) alphabet.insert(alphabet.size(),
                                                    mtsm_pkg::BYTE_W'($urandom));
      if (session == 0 || $urandom_range(0, 2) == 0) begin
        enqueue_word(make_word(mtsm_pkg::OP_CLEAR));
        gen_count = 0;
        if ($urandom_range(0, 2) == 0) enqueue_word(make_word(mtsm_pkg::OP_WRITE));
        if ($urandom_range(0, 3) == 0) send_text($urandom_range(1, 4), 1'b1);
      end
      ntok = $urandom_range(1, 10);
      repeat (ntok) load_token(mtsm_pkg::IDENT_W'($urandom), rand_token_len());
      repeat ($urandom_range(2, 6)) send_text($urandom_range(1, 24), $urandom_range(0, 4) != 0);
      if ($urandom_range(0, 3) == 0) enqueue_word(make_word($urandom_range(0, 3) == 0 ?
                                                            mtsm_pkg::OP_CLEAR :
                                                            mtsm_pkg::OP_SCAN));
      session++;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_words.size() != 0 || item_bus.valid || expected_results.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
